// ===== hw/rtl/lcg_pkg.sv =====
package lcg_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int GATE_W = FRAC_BITS + 1;
	localparam int CAND_W = FRAC_BITS + 2;
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int QUOT_W = PROD_W - FRAC_BITS;

	localparam int PIPE_DEPTH = 11;

	localparam logic signed [DATA_WIDTH-1:0] Q_ONE =
		{{(DATA_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	localparam int KNOT_COUNT = 9;
	localparam int KNOT_SRC_W = 16;
	localparam int KNOT_PAD   = 9;
	localparam int KNOT_W     = FRAC_BITS + 1;
	localparam int KNOT_IDX_W = 4;
	localparam int KNOT_WIDE  = KNOT_SRC_W + KNOT_PAD + 1;

	localparam logic [KNOT_SRC_W-1:0] TANH_KNOTS [KNOT_COUNT] = '{
		16'd0, 16'd30285, 16'd49913, 16'd59320, 16'd63179,
		16'd64659, 16'd65212, 16'd65417, 16'd65492
	};

	function automatic logic [KNOT_W-1:0] tanh_knot(input logic [KNOT_IDX_W-1:0] k);
		logic [KNOT_WIDE-1:0] src;
		logic [KNOT_WIDE-1:0] w;
		logic [KNOT_WIDE-1:0] sh;
		if (k < KNOT_IDX_W'(KNOT_COUNT)) begin
			src = {{(KNOT_PAD+1){1'b0}}, TANH_KNOTS[k]};
		end else begin
			src = {{(KNOT_PAD+1){1'b0}}, TANH_KNOTS[KNOT_COUNT-1]};
		end
		w  = (src << KNOT_PAD) +
			(KNOT_WIDE'(1) << (KNOT_PAD + KNOT_SRC_W - 1 - FRAC_BITS));
		sh = w >> (KNOT_PAD + KNOT_SRC_W - FRAC_BITS);
		return sh[KNOT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/lcg_mulq.sv =====
module lcg_mulq (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0] a,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0] b,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0] y
);
	import lcg_pkg::*;

	localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [QUOT_W-1:0] LIM_NEG = QUOT_W'(1) << (DATA_WIDTH - 1);
	localparam logic [QUOT_W-1:0] LIM_POS = LIM_NEG - QUOT_W'(1);

	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [PROD_W-1:0]     p_s1;
	logic                  neg_s1;
	logic [QUOT_W-1:0]     quot;
	logic [QUOT_W-1:0]     lim;
	logic [QUOT_W-1:0]     qsat;

	assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= {{DATA_WIDTH{1'b0}}, mag_a} * {{DATA_WIDTH{1'b0}}, mag_b} + ROUND;
			neg_s1 <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
		end
	end

	assign quot = p_s1[PROD_W-1:FRAC_BITS];
	assign lim  = neg_s1 ? LIM_NEG : LIM_POS;
	assign qsat = (quot > lim) ? lim : quot;

	always_ff @(posedge clk) begin
		if (en) begin
			y <= neg_s1 ? -$signed(qsat[DATA_WIDTH-1:0]) : $signed(qsat[DATA_WIDTH-1:0]);
		end
	end

endmodule

// ===== hw/rtl/lcg_tanh.sv =====
module lcg_tanh (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0] x,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0] th
);
	import lcg_pkg::*;

	localparam int TERM_W = 2 * FRAC_BITS;

	logic [DATA_WIDTH-1:0]   ax;
	logic [KNOT_IDX_W-1:0]   k;
	logic [FRAC_BITS-2:0]    fr;
	logic [KNOT_W-1:0]       dlt;
	logic                    neg_s1;
	logic                    hold_s1;
	logic [KNOT_W-1:0]       base_s1;
	logic [TERM_W-1:0]       term_s1;
	logic [TERM_W-1:0]       term_sh;
	logic [KNOT_W-1:0]       yv;

	assign ax  = x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
	assign k   = {1'b0, ax[FRAC_BITS+1:FRAC_BITS-1]};
	assign fr  = ax[FRAC_BITS-2:0];
	assign dlt = tanh_knot(k + 1'b1) - tanh_knot(k);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= x[DATA_WIDTH-1];
			hold_s1 <= |ax[DATA_WIDTH-1:FRAC_BITS+2];
			base_s1 <= tanh_knot(k);
			term_s1 <= TERM_W'(dlt) * TERM_W'(fr) + (TERM_W'(1) << (FRAC_BITS - 2));
		end
	end

	assign term_sh = term_s1 >> (FRAC_BITS - 1);
	assign yv = hold_s1 ? tanh_knot(KNOT_IDX_W'(KNOT_COUNT - 1))
		: base_s1 + term_sh[KNOT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			th <= neg_s1 ? -$signed(DATA_WIDTH'(yv)) : $signed(DATA_WIDTH'(yv));
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) |-> (th <= $signed(DATA_WIDTH'(tanh_knot(KNOT_IDX_W'(KNOT_COUNT - 1)))))
			&& (th >= -$signed(DATA_WIDTH'(tanh_knot(KNOT_IDX_W'(KNOT_COUNT - 1))))))
		else $error("tanh result beyond last knot");

	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(th))
		else $error("tanh result moved during stall");

endmodule

// ===== hw/rtl/lstm_cell_gate_gradient.sv =====
// LSTM cell backward step for one hidden unit, signed Q16.16. Each transfer on the
// item channel yields exactly one transfer on the result channel, in order; one
// item is taken every cycle while the result side does not stall. The pipeline
// follows the chain tanh(cell) -> tanh squared -> hidden-path product -> cell
// gradient sum -> cell gradient times operand -> times gate factor, each product
// unit taking two stages (multiply, then round and saturate). A stall on the result
// side freezes the whole pipeline. All results saturate to 32 bits.
module lstm_cell_gate_gradient (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_hidden,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_cell,
	input  logic        [lcg_pkg::GATE_W-1:0]      input_gate,
	input  logic        [lcg_pkg::GATE_W-1:0]      output_gate,
	input  logic        [lcg_pkg::GATE_W-1:0]      forget_gate,
	input  logic signed [lcg_pkg::CAND_W-1:0]      candidate,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0]  cell_now,
	input  logic signed [lcg_pkg::DATA_WIDTH-1:0]  cell_before,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_pre_input,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_pre_output,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_pre_forget,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_pre_candidate,
	output logic signed [lcg_pkg::DATA_WIDTH-1:0]  grad_cell_prev
);
	import lcg_pkg::*;

	typedef logic signed [DATA_WIDTH-1:0] q_t;

	logic                  en;
	logic [PIPE_DEPTH:1]   vld_s;

	q_t                    gh_s    [1:2];
	q_t                    gcell_s [1:6];
	logic signed [CAND_W-1:0] cand_s [1:7];
	q_t                    cb_s    [1:7];
	logic [GATE_W-1:0]     ig_s    [1:7];
	logic [GATE_W-1:0]     fg_s    [1:7];
	q_t                    gho_s   [3:4];
	q_t                    oo_s    [3:4];
	q_t                    ii_s    [3:9];
	q_t                    ff_s    [3:9];
	q_t                    cc_s    [3:9];
	q_t                    dout_s  [7:11];
	q_t                    dprev_s [10:11];

	q_t ig_q, og_q, fg_q, cand_q;
	q_t gho, ii, oo, ff, cc, th, th2, ght, hp, dout;
	q_t one_m_th2;
	logic signed [DATA_WIDTH:0] gc_sum;
	q_t gc_s7;
	q_t gcc, gcb, gci, gcf;

	assign en         = !vld_s[PIPE_DEPTH] || result_ready;
	assign item_ready = en;
	assign result_valid = vld_s[PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], item_valid};
		end
	end

	assign ig_q   = q_t'(input_gate);
	assign og_q   = q_t'(output_gate);
	assign fg_q   = q_t'(forget_gate);
	assign cand_q = q_t'(candidate);

	// stage 1-2: tanh of the cell, gate factors, candidate squared, hidden times output gate
	lcg_tanh u_tanh (.clk, .arst_n, .en, .x(cell_now), .th(th));
	lcg_mulq u_gho (.clk, .en, .a(grad_hidden), .b(og_q), .y(gho));
	lcg_mulq u_ii  (.clk, .en, .a(ig_q), .b(Q_ONE - ig_q), .y(ii));
	lcg_mulq u_oo  (.clk, .en, .a(og_q), .b(Q_ONE - og_q), .y(oo));
	lcg_mulq u_ff  (.clk, .en, .a(fg_q), .b(Q_ONE - fg_q), .y(ff));
	lcg_mulq u_cc  (.clk, .en, .a(cand_q), .b(cand_q), .y(cc));

	// stage 3-4
	lcg_mulq u_th2 (.clk, .en, .a(th), .b(th), .y(th2));
	lcg_mulq u_ght (.clk, .en, .a(gh_s[2]), .b(th), .y(ght));

	// stage 5-6
	assign one_m_th2 = Q_ONE - th2;
	lcg_mulq u_hp   (.clk, .en, .a(gho_s[4]), .b(one_m_th2), .y(hp));
	lcg_mulq u_dout (.clk, .en, .a(ght), .b(oo_s[4]), .y(dout));

	// stage 7: total cell gradient
	assign gc_sum = {gcell_s[6][DATA_WIDTH-1], gcell_s[6]} + {hp[DATA_WIDTH-1], hp};

	always_ff @(posedge clk) begin
		if (en) begin
			if (gc_sum[DATA_WIDTH] != gc_sum[DATA_WIDTH-1]) begin
				gc_s7 <= gc_sum[DATA_WIDTH] ? Q_MIN : Q_MAX;
			end else begin
				gc_s7 <= gc_sum[DATA_WIDTH-1:0];
			end
		end
	end

	// stage 8-9
	lcg_mulq u_gcc (.clk, .en, .a(gc_s7), .b(q_t'(cand_s[7])), .y(gcc));
	lcg_mulq u_gcb (.clk, .en, .a(gc_s7), .b(cb_s[7]), .y(gcb));
	lcg_mulq u_gci (.clk, .en, .a(gc_s7), .b(q_t'(ig_s[7])), .y(gci));
	lcg_mulq u_gcf (.clk, .en, .a(gc_s7), .b(q_t'(fg_s[7])), .y(gcf));

	// stage 10-11: results
	lcg_mulq u_din   (.clk, .en, .a(gcc), .b(ii_s[9]), .y(grad_pre_input));
	lcg_mulq u_dfg   (.clk, .en, .a(gcb), .b(ff_s[9]), .y(grad_pre_forget));
	lcg_mulq u_dcand (.clk, .en, .a(gci), .b(Q_ONE - cc_s[9]), .y(grad_pre_candidate));

	assign grad_pre_output = dout_s[11];
	assign grad_cell_prev  = dprev_s[11];

	always_ff @(posedge clk) begin
		if (en) begin
			gh_s[1] <= grad_hidden;
			gh_s[2] <= gh_s[1];
			gcell_s[1] <= grad_cell;
			cand_s[1]  <= candidate;
			cb_s[1]    <= cell_before;
			ig_s[1]    <= input_gate;
			fg_s[1]    <= forget_gate;
			for (int i = 2; i <= 6; i++) begin
				gcell_s[i] <= gcell_s[i-1];
			end
			for (int i = 2; i <= 7; i++) begin
				cand_s[i] <= cand_s[i-1];
				cb_s[i]   <= cb_s[i-1];
				ig_s[i]   <= ig_s[i-1];
				fg_s[i]   <= fg_s[i-1];
			end
			gho_s[3] <= gho;
			gho_s[4] <= gho_s[3];
			oo_s[3]  <= oo;
			oo_s[4]  <= oo_s[3];
			ii_s[3]  <= ii;
			ff_s[3]  <= ff;
			cc_s[3]  <= cc;
			for (int i = 4; i <= 9; i++) begin
				ii_s[i] <= ii_s[i-1];
				ff_s[i] <= ff_s[i-1];
				cc_s[i] <= cc_s[i-1];
			end
			dout_s[7] <= dout;
			for (int i = 8; i <= 11; i++) begin
				dout_s[i] <= dout_s[i-1];
			end
			dprev_s[10] <= gcf;
			dprev_s[11] <= dprev_s[10];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !item_ready)
		else $error("item taken while result side stalls");

	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> vld_s[1])
		else $error("transfer lost at pipeline entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid)
		else $error("pending result dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[4] && en) |-> (one_m_th2 > 0))
		else $error("one minus tanh squared not positive");

endmodule
